// ===== rtl/core/mtb_pkg.sv =====
// mtb_pkg: shared types and constants for the mean threshold binarizer.
// Used by every module under rtl/core; depends on nothing.
package mtb_pkg;

	localparam int unsigned MAX_PIXELS_DEF = 4096;
	localparam int unsigned QUEUE_DEPTH    = 4;

	localparam int unsigned GREY_W     = 8;
	localparam int unsigned RGB_SUM_W  = 10;
	localparam int unsigned PROD_W     = 20;
	// floor(s/3) == (s*683) >> 11 for every s up to 765
	localparam int unsigned GREY_RECIP = 683;
	localparam int unsigned GREY_SHIFT = 11;

	localparam logic [GREY_W-1:0] LEVEL_WHITE = 8'd255;
	localparam logic [GREY_W-1:0] LEVEL_BLACK = 8'd0;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EMIT = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic              op;
		logic [GREY_W-1:0] red;
		logic [GREY_W-1:0] green;
		logic [GREY_W-1:0] blue;
		logic              last_pixel;
	} req_t;

	typedef struct packed {
		logic [GREY_W-1:0] level;
		logic              is_white;
		logic [GREY_W-1:0] region_mean;
		logic              last_out;
	} res_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [GREY_W-1:0] grey;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_DIV
	} back_state_t;

endpackage

// ===== rtl/core/mtb_front.sv =====
// mtb_front: accepts requests, classifies them and converts RGB to grey.
// Depends on mtb_pkg; pushes commands into mtb_queue.
module mtb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mtb_pkg::req_t      request,
	input  mtb_pkg::q_status_t qstat,
	output logic               push,
	output mtb_pkg::cmd_t      cmd
);

	logic                             valid_s1;
	mtb_pkg::cmd_kind_t               kind_s1;
	logic [mtb_pkg::RGB_SUM_W-1:0]    rgb_sum_s1;
	logic                             last_s1;
	logic                             accept;
	logic [mtb_pkg::PROD_W-1:0]       prod;

	assign busy   = valid_s1 && qstat.full;
	assign accept = start && !busy;
	assign push   = valid_s1 && !qstat.full;

	// reciprocal multiply replaces the divide by three
	assign prod = mtb_pkg::PROD_W'(rgb_sum_s1) * mtb_pkg::PROD_W'(mtb_pkg::GREY_RECIP);

	assign cmd.kind = kind_s1;
	assign cmd.grey = prod[mtb_pkg::GREY_SHIFT +: mtb_pkg::GREY_W];
	assign cmd.last = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= request.op ? mtb_pkg::CMD_EMIT : mtb_pkg::CMD_LOAD;
			rgb_sum_s1 <= mtb_pkg::RGB_SUM_W'(request.red)
				+ mtb_pkg::RGB_SUM_W'(request.green)
				+ mtb_pkg::RGB_SUM_W'(request.blue);
			last_s1    <= request.last_pixel;
		end
	end

endmodule

// ===== rtl/core/mtb_queue.sv =====
// mtb_queue: short command FIFO between the front and back parts.
// Depends on mtb_pkg.
module mtb_queue #(
	parameter int unsigned DEPTH = mtb_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mtb_pkg::cmd_t      wdata,
	input  logic               pop,
	output mtb_pkg::cmd_t      head,
	output mtb_pkg::q_status_t qstat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	mtb_pkg::cmd_t   slots_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == NW'(DEPTH));
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = slots_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/mtb_back.sv =====
// mtb_back: executes queued commands: grey store, sum, mean divider, emit.
// Depends on mtb_pkg; pops commands from mtb_queue.
module mtb_back #(
	parameter int unsigned MAX_PIXELS = mtb_pkg::MAX_PIXELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mtb_pkg::q_status_t qstat,
	input  mtb_pkg::cmd_t      head,
	output logic               pop,
	output logic               strobe,
	output mtb_pkg::res_t      result
);

	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
	localparam int unsigned SW = CW + mtb_pkg::GREY_W;
	localparam int unsigned BW = $clog2(mtb_pkg::GREY_W);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

	mtb_pkg::back_state_t        state_q, state_n;
	logic [CW-1:0]               cnt_q;
	logic [SW-1:0]               sum_q;
	logic [mtb_pkg::GREY_W-1:0]  mean_q;
	logic [AW-1:0]               rptr_q;
	logic                        done_q;
	logic                        strobe_q;
	mtb_pkg::res_t               result_q;

	logic [SW-1:0]               rem_q;
	logic [mtb_pkg::GREY_W-1:0]  quot_q;
	logic [BW-1:0]               bit_q;
	logic                        last_rd_q;
	logic [mtb_pkg::GREY_W-1:0]  rd_data_q;

	logic [mtb_pkg::GREY_W-1:0]  grey_store [MAX_PIXELS];

	logic                        take_cmd;
	logic                        is_load;
	logic                        is_emit;
	logic                        close;
	logic [CW-1:0]               eff_cnt;
	logic [SW-1:0]               eff_sum;
	logic                        room;
	logic [CW-1:0]               new_cnt;
	logic [SW-1:0]               new_sum;
	logic [AW-1:0]               rd_idx;
	logic                        rd_last;
	logic [SW-1:0]               div_shift;
	logic                        div_ge;
	logic [SW-1:0]               rem_nx;
	logic [mtb_pkg::GREY_W-1:0]  quot_nx;
	logic                        white;

	// datapath
	always_comb begin
		eff_cnt   = done_q ? '0 : cnt_q;
		eff_sum   = done_q ? '0 : sum_q;
		room      = (eff_cnt < MAX_CNT);
		new_cnt   = room ? eff_cnt + CW'(1) : eff_cnt;
		new_sum   = room ? eff_sum + SW'(head.grey) : eff_sum;
		rd_idx    = (CW'(rptr_q) >= cnt_q) ? '0 : rptr_q;
		rd_last   = ((CW'(rd_idx) + CW'(1)) == cnt_q);
		div_shift = SW'(cnt_q) << bit_q;
		div_ge    = (rem_q >= div_shift);
		rem_nx    = div_ge ? rem_q - div_shift : rem_q;
		quot_nx   = quot_q | (div_ge ? (mtb_pkg::GREY_W'(1) << bit_q) : '0);
		white     = (rd_data_q > mean_q);
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			mtb_pkg::BK_IDLE: begin
				if (close) begin
					state_n = mtb_pkg::BK_DIV;
				end else if (is_emit) begin
					state_n = mtb_pkg::BK_READ;
				end
			end
			mtb_pkg::BK_READ: begin
				state_n = mtb_pkg::BK_IDLE;
			end
			mtb_pkg::BK_DIV: begin
				if (bit_q == '0) begin
					state_n = mtb_pkg::BK_IDLE;
				end
			end
			default: begin
				state_n = mtb_pkg::BK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		take_cmd = (state_q == mtb_pkg::BK_IDLE) && !qstat.empty;
		is_load  = take_cmd && (head.kind == mtb_pkg::CMD_LOAD);
		// emit before close or on an empty region gives nothing
		is_emit  = take_cmd && (head.kind == mtb_pkg::CMD_EMIT) && done_q && (cnt_q != '0);
		close    = is_load && head.last;
		pop      = take_cmd;
	end

	assign strobe = strobe_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mtb_pkg::BK_IDLE;
			cnt_q    <= '0;
			sum_q    <= '0;
			mean_q   <= '0;
			rptr_q   <= '0;
			done_q   <= 1'b0;
			strobe_q <= 1'b0;
			bit_q    <= '0;
		end else begin
			state_q  <= state_n;
			strobe_q <= (state_q == mtb_pkg::BK_READ);
			if (is_load) begin
				cnt_q  <= new_cnt;
				sum_q  <= new_sum;
				rptr_q <= '0;
				done_q <= head.last;
			end
			if (is_emit) begin
				rptr_q <= rd_last ? '0 : rd_idx + AW'(1);
			end
			if (close) begin
				bit_q <= BW'(mtb_pkg::GREY_W - 1);
			end else if (state_q == mtb_pkg::BK_DIV) begin
				bit_q <= bit_q - BW'(1);
				if (bit_q == '0) begin
					mean_q <= quot_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			rem_q  <= new_sum;
			quot_q <= '0;
		end else if (state_q == mtb_pkg::BK_DIV) begin
			rem_q  <= rem_nx;
			quot_q <= quot_nx;
		end
		if (is_emit) begin
			last_rd_q <= rd_last;
		end
		if (state_q == mtb_pkg::BK_READ) begin
			result_q.level       <= white ? mtb_pkg::LEVEL_WHITE : mtb_pkg::LEVEL_BLACK;
			result_q.is_white    <= white;
			result_q.region_mean <= mean_q;
			result_q.last_out    <= last_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (is_load && room) begin
			grey_store[eff_cnt[AW-1:0]] <= head.grey;
		end
		if (is_emit) begin
			rd_data_q <= grey_store[rd_idx];
		end
	end

endmodule

// ===== rtl/core/mean_threshold_binarizer.sv =====
// mean_threshold_binarizer: top level, global mean threshold binarization.
// Depends on mtb_pkg, mtb_front, mtb_queue and mtb_back.
//
//  channel   | ports                   | handshake
//  ----------+-------------------------+--------------------------------------
//  request   | start, busy, request    | taken at an edge with start & !busy
//  result    | strobe, result          | valid for one cycle while strobe high
//
// The front registers each request and turns RGB into grey with a reciprocal
// multiply; a 4-entry queue separates it from the back, which runs the store.
// Back steps per request: a load is taken in BK_IDLE; an emit reads the grey
// store, then compares in BK_READ; a region-closing load adds the bit-serial
// mean divider in BK_DIV. An emit passes front, queue and store read to strobe.
// Reset clears control, counts, sum and mean; the grey store is not cleared,
// every entry is written in a region before it is read.
// busy rises only when the front holds a request and the queue is full; the
// result side never stalls.
module mean_threshold_binarizer #(
	parameter int unsigned MAX_PIXELS  = mtb_pkg::MAX_PIXELS_DEF,
	parameter int unsigned QUEUE_DEPTH = mtb_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mtb_pkg::req_t request,
	output logic          strobe,
	output mtb_pkg::res_t result
);

	mtb_pkg::q_status_t qstat;
	mtb_pkg::cmd_t      push_cmd;
	mtb_pkg::cmd_t      head_cmd;
	logic               push;
	logic               pop;

	// request intake and RGB-to-grey conversion
	mtb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.qstat  (qstat),
		.push   (push),
		.cmd    (push_cmd)
	);

	// decouples intake from the store, which stalls during the mean divide
	mtb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.head   (head_cmd),
		.qstat  (qstat)
	);

	// grey store, running sum, mean divider and threshold compare
	mtb_back #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head_cmd),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ===== rtl/core/mtb_checker.sv =====
// mtb_checker: port-level assertions for mean_threshold_binarizer.
// Depends on mtb_pkg; bound to the top level at the end of this file.
module mtb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          busy,
	input logic          strobe,
	input mtb_pkg::res_t result
);

	// an emit needs a store read and a compare, so results never come back to back
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe on two consecutive cycles");

	// level follows the compare outcome
	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.is_white && result.level == mtb_pkg::LEVEL_WHITE)
			|| (!result.is_white && result.level == mtb_pkg::LEVEL_BLACK)))
		else $error("level does not match is_white");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> (!strobe && !busy))
		else $error("strobe or busy active in reset");

endmodule

bind mean_threshold_binarizer mtb_checker u_mtb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);

// ===== sim/tb.sv =====
// tb: self-checking bench for mean_threshold_binarizer, command-style request port.
// Depends on mtb_pkg and the RTL under rtl/core; it predicts every result
// itself and checks each strobed result field by field.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PIXEL_CAP   = mtb_pkg::MAX_PIXELS_DEF;
	localparam int unsigned SETTLE      = 24;   // covers the bit-serial mean divide
	localparam int unsigned QUIET_LIMIT = 2000; // cycles with no request or result
	localparam int unsigned RAND_ITEMS  = 900;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	mtb_pkg::req_t request;
	logic strobe;
	mtb_pkg::res_t result;

	mean_threshold_binarizer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.strobe  (strobe),
		.result  (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predicted block state
	// ---------------------------------------------------------------
	logic [7:0]  grey_mem [PIXEL_CAP];
	int unsigned grey_total;
	int unsigned stored_px;
	logic [7:0]  region_avg;
	int unsigned emit_idx;
	bit          region_closed;

	mtb_pkg::req_t pixel_backlog[$];   // requests still to be presented
	mtb_pkg::res_t expected_pixels[$]; // binarized pixels owed by the block

	bit          in_flight;   // request on the port, not yet taken
	int unsigned idle_pct;    // sender gap chance, percent
	int unsigned err_cnt;
	int unsigned quiet_cycles;

	// Applies one accepted request to the predicted state; emits queue
	// their binarized pixel.
	function automatic void predict_binarized(mtb_pkg::req_t rq);
		int unsigned   grey;
		int unsigned   idx;
		bit            tail;
		bit            white;
		mtb_pkg::res_t px;
		if (rq.op == mtb_pkg::CMD_LOAD) begin
			grey = (int'(rq.red) + int'(rq.green) + int'(rq.blue)) / 3;
			// a load after a closed region opens a fresh one
			if (region_closed) begin
				grey_total    = 0;
				stored_px     = 0;
				emit_idx      = 0;
				region_closed = 1'b0;
			end
			// overflow pixels are dropped but can still close the region
			if (stored_px < PIXEL_CAP) begin
				grey_mem[stored_px] = grey[7:0];
				grey_total += grey;
				stored_px++;
			end
			if (rq.last_pixel) begin
				region_avg    = (stored_px != 0) ? 8'(grey_total / stored_px) : 8'd0;
				emit_idx      = 0;
				region_closed = 1'b1;
			end
		end else if (region_closed && stored_px != 0) begin
			idx = (emit_idx >= stored_px) ? 0 : emit_idx;
			white = grey_mem[idx] > region_avg;
			tail  = (idx + 1) == stored_px;
			px.level       = white ? mtb_pkg::LEVEL_WHITE : mtb_pkg::LEVEL_BLACK;
			px.is_white    = white;
			px.region_mean = region_avg;
			px.last_out    = tail;
			expected_pixels.push_back(px);
			emit_idx = tail ? 0 : idx + 1;
		end
		// emit before close: ignored, nothing owed
	endfunction

	// ---------------------------------------------------------------
	// Driver: new request or gap at the falling edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !in_flight) begin
			if (pixel_backlog.size() > 0 && $urandom_range(1, 100) > idle_pct) begin
				request   <= pixel_backlog.pop_front();
				start     <= 1'b1;
				in_flight = 1'b1;
			end else begin
				// junk payload while start is low must be ignored
				request <= mtb_pkg::req_t'({$urandom, $urandom});
				start   <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: request acceptance and result checks at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		mtb_pkg::res_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predict_binarized(request);
				in_flight = 1'b0;
			end
			if (strobe) begin
				if (expected_pixels.size() == 0) begin
					$error("result with nothing expected: level %0d mean %0d",
						result.level, result.region_mean);
					err_cnt++;
				end else begin
					want = expected_pixels.pop_front();
					if (result.level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, result.level);
						err_cnt++;
					end
					if (result.is_white !== want.is_white) begin
						$error("is_white: expected %0d, got %0d",
							want.is_white, result.is_white);
						err_cnt++;
					end
					if (result.region_mean !== want.region_mean) begin
						$error("region_mean: expected %0d, got %0d",
							want.region_mean, result.region_mean);
						err_cnt++;
					end
					if (result.last_out !== want.last_out) begin
						$error("last_out: expected %0d, got %0d",
							want.last_out, result.last_out);
						err_cnt++;
					end
				end
			end
		end
	end

	// Watchdog: too long without a request taken or a result seen
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic void push_load(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic tail);
		mtb_pkg::req_t rq;
		rq.op         = mtb_pkg::CMD_LOAD;
		rq.red        = r;
		rq.green      = g;
		rq.blue       = b;
		rq.last_pixel = tail;
		pixel_backlog.push_back(rq);
	endfunction

	// color fields of an emit are don't-care, fill with junk
	function automatic void push_emit();
		mtb_pkg::req_t rq;
		rq            = mtb_pkg::req_t'({$urandom, $urandom});
		rq.op         = mtb_pkg::CMD_EMIT;
		pixel_backlog.push_back(rq);
	endfunction

	// biased toward the extremes of a channel
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One region: loads, maybe stray emits mid-load, then reads.
	// Returns how many requests count toward the random total.
	function automatic int unsigned push_region(int unsigned npix, int unsigned nemit);
		logic [7:0] c;
		for (int unsigned i = 0; i < npix; i++) begin
			// stray emit while the region is open: ignored by the block
			if (i > 0 && $urandom_range(0, 19) == 0)
				push_emit();
			// flat pixels make grey land on the mean more often
			if ($urandom_range(0, 3) == 0) begin
				c = pick_channel();
				push_load(c, c, c, i == npix - 1);
			end else begin
				push_load(pick_channel(), pick_channel(), pick_channel(), i == npix - 1);
			end
		end
		for (int unsigned i = 0; i < nemit; i++)
			push_emit();
		return npix + nemit;
	endfunction

	// Hold the sender until every owed result is back, then let the
	// back end finish any region close still in progress.
	task automatic drain();
		while (pixel_backlog.size() != 0 || in_flight || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned done_items;
		int unsigned npix;
		int unsigned idle_plan [4];
		arst_n        = 1'b0;
		start         = 1'b0;
		request       = '0;
		in_flight     = 1'b0;
		idle_pct      = 0;
		err_cnt       = 0;
		grey_total    = 0;
		stored_px     = 0;
		region_avg    = 8'd0;
		emit_idx      = 0;
		region_closed = 1'b0;
		idle_plan     = '{0, 69, 0, 16};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed ---
		push_emit();                           // emit before any region: ignored
		push_load(8'd0,   8'd0,   8'd0,   1'b0); // grey 0
		push_load(8'd255, 8'd255, 8'd255, 1'b0); // grey 255
		push_load(8'd255, 8'd0,   8'd0,   1'b0); // grey 85 per channel
		push_load(8'd0,   8'd255, 8'd0,   1'b0);
		push_load(8'd0,   8'd0,   8'd255, 1'b1); // mean 102
		repeat (6) push_emit();                // reads wrap past the last pixel
		push_load(8'd20,  8'd20,  8'd20,  1'b1); // one-pixel region, grey == mean
		repeat (2) push_emit();
		push_load(8'd30,  8'd30,  8'd30,  1'b0); // new region after close
		push_emit();                           // region open again: ignored
		push_load(8'd10,  8'd10,  8'd10,  1'b0);
		push_load(8'd20,  8'd21,  8'd19,  1'b1); // mean 20, last pixel equals it
		repeat (3) push_emit();
		drain();

		// --- random regions, one sender gap setting per phase ---
		foreach (idle_plan[p]) begin
			idle_pct   = idle_plan[p];
			done_items = 0;
			while (done_items < RAND_ITEMS / 4) begin
				npix = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16);
				done_items += push_region(npix, $urandom_range(0, 2 * npix + 2));
			end
			drain();
		end

		if (err_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
